[rtl/ncc_pkg.sv]
`default_nettype none

package ncc_pkg;

    localparam int MAX_PATTERN_W = 32;
    localparam int MAX_PATTERN_H = 32;
    localparam int MAX_TARGET_W  = 1024;
    localparam int TGT_H_LIMIT   = 1024;

    localparam int PIX_W   = 8;
    localparam int PDEPTH  = MAX_PATTERN_W * MAX_PATTERN_H;
    localparam int PADDR_W = $clog2(PDEPTH);
    localparam int PI_W    = $clog2(MAX_PATTERN_W);
    localparam int PJ_W    = $clog2(MAX_PATTERN_H);
    localparam int TROW_W  = $clog2(MAX_PATTERN_H);
    localparam int TCOL_W  = $clog2(MAX_TARGET_W);
    localparam int TADDR_W = TROW_W + TCOL_W;
    localparam int ROW_W   = $clog2(TGT_H_LIMIT);

    localparam int PCFG_W  = 6;
    localparam int TCFG_W  = 11;
    localparam int N_W     = 11;
    localparam int SUM_W   = 18;
    localparam int SQ_W    = 26;
    localparam int PRD_W   = 44;
    localparam int WIDE_W  = 128;
    localparam int MB_W    = 64;
    localparam int Q_W     = 16;
    localparam int POS_W   = 10;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [1:0] REG_PW = 2'd0;
    localparam logic [1:0] REG_PH = 2'd1;
    localparam logic [1:0] REG_TW = 2'd2;
    localparam logic [1:0] REG_TH = 2'd3;

    localparam logic [1:0] MSEL_C = 2'd0;
    localparam logic [1:0] MSEL_V = 2'd1;
    localparam logic [1:0] MSEL_D = 2'd2;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel;
    } t_in_word;

    typedef struct packed {
        logic signed [Q_W-1:0] correlation;
        logic [POS_W-1:0]      res_x;
        logic [POS_W-1:0]      res_y;
        logic                  flat;
        logic                  last_result;
    } t_out_word;

    typedef struct packed {
        logic       prod_run;
        logic       diff;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       cap_rhs;
        logic       cap_w;
        logic       dsq;
        logic       cmp;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic mac_done;
        logic prod_done;
        logic mul_done;
        logic flat;
        logic srch_go;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/ncc_template_match_unit.sv]
// Channel   Direction  Handshake                Word
// input     in         i_in_valid / o_in_stall  i_in_word  (func, pixel)
// output    out        o_out_valid / i_out_stall o_out_word (correlation, res_x, res_y,
//                                                flat, last_result)
// config    in         APB psel/penable/pwrite  paddr, pwdata, prdata
//
// A pattern pixel, or a target pixel that completes no window, does not stall the input.
// A target pixel that completes a window first forms the window sums and the six
// products, then uses the shared shift-add multiplier for the squared cross term,
// the variance product and up to sixteen steps of the root search.
// The input is stalled while a window is in work; a finished word waits in the
// output register while the next pixel is taken. Reset needs no clearing pass.

`default_nettype none

module ncc_template_match_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire ncc_pkg::t_in_word           i_in_word,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output ncc_pkg::t_out_word               o_out_word,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ncc_pkg::APB_AW-1:0]  paddr,
    input  wire logic [ncc_pkg::APB_DW-1:0]  pwdata,
    output logic [ncc_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);
    import ncc_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy;
    logic accept;
    logic cfg_we;

    assign pready     = 1'b1;
    assign cfg_we     = psel && penable && pwrite;
    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    ncc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_target (i_in_word.func),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    ncc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_word   (i_in_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (paddr[3:2]),
        .i_cfg_data  (pwdata),
        .o_cfg_rdata (prdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over an unread word");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.flat) |-> (o_out_word.correlation == '0))
        else $error("flat window with nonzero correlation");

    a_idle_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!cmd.mul_start && !cmd.load_out && !cmd.prod_run))
        else $error("datapath command while taking a pixel");

endmodule

`default_nettype wire

[rtl/ncc_mul.sv]
`default_nettype none

module ncc_mul (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ncc_pkg::WIDE_W-1:0] i_op_a,
    input  wire logic [ncc_pkg::MB_W-1:0]   i_op_b,
    output logic                            o_done,
    output logic [ncc_pkg::WIDE_W-1:0]      o_product
);
    import ncc_pkg::*;

    logic              r_busy;
    logic [WIDE_W-1:0] r_a;
    logic [MB_W-1:0]   r_b;
    logic [WIDE_W-1:0] r_acc;

    assign o_done    = r_busy && (r_b == '0);
    assign o_product = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_a    <= i_op_a;
            r_b    <= i_op_b;
            r_acc  <= '0;
        end else if (r_busy) begin
            if (o_done) begin
                r_busy <= 1'b0;
            end else begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/ncc_ctrl.sv]
`default_nettype none

module ncc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_target,
    input  wire ncc_pkg::t_sts i_sts,
    output ncc_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import ncc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAC  = 4'd1;
    localparam logic [3:0] S_PROD = 4'd2;
    localparam logic [3:0] S_DIFF = 4'd3;
    localparam logic [3:0] S_MULC = 4'd4;
    localparam logic [3:0] S_WC   = 4'd5;
    localparam logic [3:0] S_MULV = 4'd6;
    localparam logic [3:0] S_WV   = 4'd7;
    localparam logic [3:0] S_LOOP = 4'd8;
    localparam logic [3:0] S_DSQ  = 4'd9;
    localparam logic [3:0] S_MULD = 4'd10;
    localparam logic [3:0] S_WD   = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MSEL_C;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept && i_target && i_sts.emit) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (i_sts.mac_done) begin
                    n_state = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.prod_run = 1'b1;
                if (i_sts.prod_done) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_MULC;
            end
            S_MULC: begin
                if (i_sts.flat) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MSEL_C;
                    n_state         = S_WC;
                end
            end
            S_WC: begin
                if (i_sts.mul_done) begin
                    o_cmd.cap_rhs = 1'b1;
                    n_state       = S_MULV;
                end
            end
            S_MULV: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MSEL_V;
                n_state         = S_WV;
            end
            S_WV: begin
                if (i_sts.mul_done) begin
                    o_cmd.cap_w = 1'b1;
                    n_state     = S_LOOP;
                end
            end
            S_LOOP: begin
                n_state = i_sts.srch_go ? S_DSQ : S_FIN;
            end
            S_DSQ: begin
                o_cmd.dsq = 1'b1;
                n_state   = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MSEL_D;
                n_state         = S_WD;
            end
            S_WD: begin
                if (i_sts.mul_done) begin
                    o_cmd.cmp = 1'b1;
                    n_state   = S_LOOP;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[rtl/ncc_dp.sv]
`default_nettype none

module ncc_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire ncc_pkg::t_in_word          i_in_word,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [ncc_pkg::APB_DW-1:0] i_cfg_data,
    output logic [ncc_pkg::APB_DW-1:0]      o_cfg_rdata,
    input  wire ncc_pkg::t_cmd              i_cmd,
    output ncc_pkg::t_sts                   o_sts,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output ncc_pkg::t_out_word              o_out_word
);
    import ncc_pkg::*;

    logic [PCFG_W-1:0] r_cfg_pw, r_cfg_ph;
    logic [TCFG_W-1:0] r_cfg_tw, r_cfg_th;
    logic [PCFG_W-1:0] pw, ph;
    logic [TCFG_W-1:0] tw, th;
    logic [N_W-1:0]    n;

    logic [PADDR_W-1:0] r_pidx;
    logic [SUM_W-1:0]   r_psum;
    logic [SQ_W-1:0]    r_psq;
    logic [TCOL_W-1:0]  r_col;
    logic [ROW_W-1:0]   r_row;

    logic [PIX_W-1:0] r_pmem [PDEPTH];
    logic [PIX_W-1:0] r_tmem [MAX_PATTERN_H * MAX_TARGET_W];
    logic [PIX_W-1:0] r_pdat, r_tdat;

    logic [PADDR_W-1:0] pidx0, pidx_n;
    logic [PADDR_W:0]   pnext;
    logic [TCOL_W:0]    col1;
    logic [ROW_W:0]     row1;
    logic               emit, last;
    logic               pat_we, tgt_we;

    logic [TCOL_W-1:0]  r_x;
    logic [ROW_W-1:0]   r_y;
    logic               r_last;
    logic [PI_W-1:0]    r_i;
    logic [PJ_W-1:0]    r_j;
    logic [PADDR_W-1:0] r_pbase;
    logic               r_issue, r_rd_v, r_rd_last;
    logic               issue_last;
    logic [SUM_W-1:0]   r_st;
    logic [SQ_W-1:0]    r_st2, r_spt;

    logic [2:0]         r_pstep;
    logic [SQ_W-1:0]    prd_a;
    logic [SUM_W-1:0]   prd_b;
    logic [PRD_W-1:0]   r_prd [6];

    logic [PRD_W-1:0]   r_vp, r_vt, r_cabs;
    logic               r_neg, r_flat;
    logic [WIDE_W-1:0]  r_rhs, r_w;
    logic [Q_W-1:0]     r_lo, r_hi, r_mid;
    logic [Q_W:0]       mid_sum;
    logic [Q_W-1:0]     mid, dval;
    logic [2*Q_W-1:0]   r_dsq;

    logic [WIDE_W-1:0]  mul_a;
    logic [MB_W-1:0]    mul_b;
    logic               mul_done;
    logic [WIDE_W-1:0]  mul_p;

    logic               r_out_valid;
    t_out_word          r_out;
    logic [Q_W-1:0]     corr;

    always_comb begin
        pw = (r_cfg_pw == '0) ? PCFG_W'(1) :
             (r_cfg_pw > PCFG_W'(MAX_PATTERN_W)) ? PCFG_W'(MAX_PATTERN_W) : r_cfg_pw;
        ph = (r_cfg_ph == '0) ? PCFG_W'(1) :
             (r_cfg_ph > PCFG_W'(MAX_PATTERN_H)) ? PCFG_W'(MAX_PATTERN_H) : r_cfg_ph;
        tw = (r_cfg_tw == '0) ? TCFG_W'(1) :
             (r_cfg_tw > TCFG_W'(MAX_TARGET_W)) ? TCFG_W'(MAX_TARGET_W) : r_cfg_tw;
        th = (r_cfg_th == '0) ? TCFG_W'(1) :
             (r_cfg_th > TCFG_W'(TGT_H_LIMIT)) ? TCFG_W'(TGT_H_LIMIT) : r_cfg_th;
        n  = N_W'(pw) * N_W'(ph);
    end

    always_comb begin
        unique case (i_cfg_idx)
            REG_PW:  o_cfg_rdata = APB_DW'(r_cfg_pw);
            REG_PH:  o_cfg_rdata = APB_DW'(r_cfg_ph);
            REG_TW:  o_cfg_rdata = APB_DW'(r_cfg_tw);
            REG_TH:  o_cfg_rdata = APB_DW'(r_cfg_th);
            default: o_cfg_rdata = '0;
        endcase
    end

    always_comb begin
        pidx0  = ((PADDR_W+1)'(r_pidx) >= (PADDR_W+1)'(n)) ? '0 : r_pidx;
        pnext  = (PADDR_W+1)'(pidx0) + 1'b1;
        pidx_n = (pnext >= (PADDR_W+1)'(n)) ? '0 : pnext[PADDR_W-1:0];
        col1   = (TCOL_W+1)'(r_col) + 1'b1;
        row1   = (ROW_W+1)'(r_row) + 1'b1;
        emit   = (col1 >= (TCOL_W+1)'(pw)) && (row1 >= (ROW_W+1)'(ph));
        last   = (col1 >= (TCOL_W+1)'(tw)) && (row1 >= (ROW_W+1)'(th));
        pat_we = i_accept && !i_in_word.func;
        tgt_we = i_accept && i_in_word.func;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pw <= PCFG_W'(MAX_PATTERN_W);
            r_cfg_ph <= PCFG_W'(MAX_PATTERN_H);
            r_cfg_tw <= TCFG_W'(MAX_TARGET_W);
            r_cfg_th <= TCFG_W'(TGT_H_LIMIT);
            r_pidx   <= '0;
            r_psum   <= '0;
            r_psq    <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PW:  r_cfg_pw <= i_cfg_data[PCFG_W-1:0];
                REG_PH:  r_cfg_ph <= i_cfg_data[PCFG_W-1:0];
                REG_TW:  r_cfg_tw <= i_cfg_data[TCFG_W-1:0];
                REG_TH:  r_cfg_th <= i_cfg_data[TCFG_W-1:0];
                default: r_cfg_pw <= r_cfg_pw;
            endcase
            if (i_cfg_idx == REG_PW || i_cfg_idx == REG_PH) begin
                r_pidx <= '0;
                r_psum <= '0;
                r_psq  <= '0;
            end
            r_col <= '0;
            r_row <= '0;
        end else if (pat_we) begin
            if (pidx0 == '0) begin
                r_psum <= SUM_W'(i_in_word.pixel);
                r_psq  <= SQ_W'(i_in_word.pixel) * SQ_W'(i_in_word.pixel);
            end else begin
                r_psum <= r_psum + SUM_W'(i_in_word.pixel);
                r_psq  <= r_psq + SQ_W'(i_in_word.pixel) * SQ_W'(i_in_word.pixel);
            end
            r_pidx <= pidx_n;
        end else if (tgt_we) begin
            if (col1 >= (TCOL_W+1)'(tw)) begin
                r_col <= '0;
                r_row <= (row1 >= (ROW_W+1)'(th)) ? '0 : row1[ROW_W-1:0];
            end else begin
                r_col <= col1[TCOL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            r_pmem[pidx0] <= i_in_word.pixel;
        end
        r_pdat <= r_pmem[r_pbase + PADDR_W'(r_i)];
    end

    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tmem[{r_row[TROW_W-1:0], r_col}] <= i_in_word.pixel;
        end
        r_tdat <= r_tmem[{TROW_W'(r_y[TROW_W-1:0] + TROW_W'(r_j)),
                          TCOL_W'(r_x + TCOL_W'(r_i))}];
    end

    assign issue_last = (PCFG_W'(r_i) == pw - 1'b1) && (PCFG_W'(r_j) == ph - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_rd_v  <= 1'b0;
        end else begin
            r_rd_v <= r_issue;
            if (tgt_we && emit) begin
                r_issue <= 1'b1;
            end else if (r_issue && issue_last) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= issue_last;
        if (tgt_we && emit) begin
            r_x     <= TCOL_W'(col1 - (TCOL_W+1)'(pw));
            r_y     <= ROW_W'(row1 - (ROW_W+1)'(ph));
            r_last  <= last;
            r_i     <= '0;
            r_j     <= '0;
            r_pbase <= '0;
            r_st    <= '0;
            r_st2   <= '0;
            r_spt   <= '0;
            r_pstep <= '0;
        end else begin
            if (r_issue) begin
                if (PCFG_W'(r_i) == pw - 1'b1) begin
                    r_i     <= '0;
                    r_j     <= r_j + 1'b1;
                    r_pbase <= r_pbase + PADDR_W'(pw);
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            if (r_rd_v) begin
                r_st  <= r_st + SUM_W'(r_tdat);
                r_st2 <= r_st2 + SQ_W'(r_tdat) * SQ_W'(r_tdat);
                r_spt <= r_spt + SQ_W'(r_tdat) * SQ_W'(r_pdat);
            end
            if (i_cmd.prod_run) begin
                r_pstep <= r_pstep + 1'b1;
            end
        end
    end

    always_comb begin
        unique case (r_pstep)
            3'd0:    begin prd_a = r_psq;          prd_b = SUM_W'(n); end
            3'd1:    begin prd_a = SQ_W'(r_psum);  prd_b = r_psum;    end
            3'd2:    begin prd_a = r_st2;          prd_b = SUM_W'(n); end
            3'd3:    begin prd_a = SQ_W'(r_st);    prd_b = r_st;      end
            3'd4:    begin prd_a = r_spt;          prd_b = SUM_W'(n); end
            3'd5:    begin prd_a = SQ_W'(r_psum);  prd_b = r_st;      end
            default: begin prd_a = '0;             prd_b = '0;        end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_run) begin
            r_prd[r_pstep] <= PRD_W'(prd_a) * PRD_W'(prd_b);
        end
    end

    always_comb begin
        mid_sum = (Q_W+1)'(r_lo) + (Q_W+1)'(r_hi) + 1'b1;
        mid     = mid_sum[Q_W:1];
        dval    = Q_W'({mid, 1'b0} - (Q_W+1)'(1));
        unique case (i_cmd.mul_sel)
            MSEL_C:  begin mul_a = WIDE_W'(r_cabs); mul_b = MB_W'(r_cabs); end
            MSEL_V:  begin mul_a = WIDE_W'(r_vp);   mul_b = MB_W'(r_vt);   end
            MSEL_D:  begin mul_a = r_w;             mul_b = MB_W'(r_dsq);  end
            default: begin mul_a = '0;              mul_b = '0;            end
        endcase
    end

    ncc_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.mul_start),
        .i_op_a    (mul_a),
        .i_op_b    (mul_b),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_vp   <= (r_prd[0] >= r_prd[1]) ? r_prd[0] - r_prd[1] : '0;
            r_vt   <= (r_prd[2] >= r_prd[3]) ? r_prd[2] - r_prd[3] : '0;
            r_neg  <= r_prd[4] < r_prd[5];
            r_cabs <= (r_prd[4] < r_prd[5]) ? r_prd[5] - r_prd[4] : r_prd[4] - r_prd[5];
            r_flat <= (r_prd[0] <= r_prd[1]) || (r_prd[2] <= r_prd[3]);
            r_lo   <= '0;
            r_hi   <= Q_W'(1) << (Q_W - 1);
        end
        if (i_cmd.cap_rhs) begin
            r_rhs <= mul_p << 32;
        end
        if (i_cmd.cap_w) begin
            r_w <= mul_p;
        end
        if (i_cmd.dsq) begin
            r_mid <= mid;
            r_dsq <= (2*Q_W)'(dval) * (2*Q_W)'(dval);
        end
        if (i_cmd.cmp) begin
            if (mul_p <= r_rhs) begin
                r_lo <= r_mid;
            end else begin
                r_hi <= r_mid - 1'b1;
            end
        end
    end

    always_comb begin
        if (r_flat) begin
            corr = '0;
        end else if (r_neg) begin
            corr = Q_W'((Q_W+1)'(0) - (Q_W+1)'(r_lo));
        end else if (r_lo[Q_W-1]) begin
            corr = {1'b0, {(Q_W-1){1'b1}}};
        end else begin
            corr = r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.correlation <= corr;
            r_out.res_x       <= POS_W'(r_x);
            r_out.res_y       <= POS_W'(r_y);
            r_out.flat        <= r_flat;
            r_out.last_result <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        o_sts.emit      = emit;
        o_sts.mac_done  = r_rd_v && r_rd_last;
        o_sts.prod_done = (r_pstep == 3'd5);
        o_sts.mul_done  = mul_done;
        o_sts.flat      = r_flat;
        o_sts.srch_go   = r_lo < r_hi;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire
